// ----- hdl/multi_mode_audio_effect_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-mode audio effect core
// Concurrent checks that are compiled only in simulation. Each use relies on
// the including module having signals named clk and rst.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_AUDIO_EFFECT_CORE_ASSERT_SVH
`define MULTI_MODE_AUDIO_EFFECT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define MMAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked at every clock edge, reset included.
`define MMAE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MMAE_ASSERT(lbl, prop, msg)
`define MMAE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/mmae_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-mode audio effect package
// Widths, constants, codes and shared types of the audio effect core.
// ----------------------------------------------------------------------------
package mmae_pkg;

  // Sample history depth and the widths that follow from it.
  localparam int HISTORY_DEPTH = 262144;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int SEEN_W        = $clog2(HISTORY_DEPTH + 1);

  // Field and register widths.
  localparam int SAMPLE_W  = 16;
  localparam int MODE_W    = 3;
  localparam int DELAY_W   = 17;
  localparam int SHIFT_W   = 5;
  localparam int RAMP_W    = 21;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_TAPS  = 3;

  // Tap distance reaches three times the delay.
  localparam int DIST_W = DELAY_W + 2;
  localparam int CALC_W = ((DIST_W > SEEN_W) ? DIST_W : SEEN_W) + 1;

  // Datapath widths.
  localparam int SUM_W    = SAMPLE_W + 2;
  localparam int PROD_W   = SAMPLE_W + RAMP_W;
  localparam int RECIP_W  = 16;
  localparam int DIVP_W   = SUM_W + RECIP_W;

  // Division by five as a multiply by a rounded-up reciprocal; exact below 2^18.
  localparam int DIV5_SHIFT = 18;
  localparam logic [RECIP_W-1:0] DIV5_RECIP = RECIP_W'(((1 << DIV5_SHIFT) + 4) / 5);

  // Reset values and limits.
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(44100);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(17);
  localparam logic [SHIFT_W-1:0] MAX_SHIFT   = SHIFT_W'(20);
  localparam logic [RAMP_W-1:0]  RAMP_MAX    = {RAMP_W{1'b1}};
  localparam logic [PROD_W-1:0]  SAT_POS_MAG = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [PROD_W-1:0]  SAT_NEG_MAG = PROD_W'(1 << (SAMPLE_W - 1));

  // Effect modes; the two codes above the envelope give silence.
  typedef enum logic [MODE_W-1:0] {
    MODE_KEEP_EVEN = 3'd0,
    MODE_KEEP_ODD  = 3'd1,
    MODE_ECHO1     = 3'd2,
    MODE_ECHO2     = 3'd3,
    MODE_ECHO3     = 3'd4,
    MODE_ENVELOPE  = 3'd5
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_DELAY = 2'd1,
    REG_SHIFT = 2'd2
  } reg_idx_t;

  // Item leaving the front stage, aligned with the history read data.
  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] x;
    logic                       parity;
    logic [NUM_TAPS-1:0]        tap_en;
    logic [RAMP_W-1:0]          ramp;
    logic [SHIFT_W-1:0]         shift;
  } front_t;

  // Access to the history memories: one write and one read per copy.
  typedef struct packed {
    logic                              we;
    logic [HIST_AW-1:0]                waddr;
    logic [SAMPLE_W-1:0]               wdata;
    logic                              re;
    logic [NUM_TAPS-1:0][HIST_AW-1:0]  raddr;
  } mem_req_t;

endpackage

// ----- hdl/mmae_in_if.sv -----
// ----------------------------------------------------------------------------
// Input sample channel
// Valid/ready channel carrying one signed PCM sample per transfer.
// ----------------------------------------------------------------------------
interface mmae_in_if import mmae_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ----- hdl/mmae_out_if.sv -----
// ----------------------------------------------------------------------------
// Output sample channel
// Valid/ready channel carrying one processed sample per transfer.
// ----------------------------------------------------------------------------
interface mmae_out_if import mmae_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ----- hdl/mmae_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface mmae_cfg_if import mmae_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DELAY_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/mmae_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered and holds until
// the next read. A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module mmae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first storage array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/mmae_ctrl.sv -----
// ----------------------------------------------------------------------------
// Audio effect front stage
// Holds the configuration registers, the history write pointer, fill count,
// sample parity and envelope state. On each input transfer it writes the
// sample to the history, issues the tap reads and hands the item on.
// ----------------------------------------------------------------------------
`include "multi_mode_audio_effect_core_assert.svh"

module mmae_ctrl import mmae_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  mmae_in_if.sink         din,
  mmae_cfg_if.sink        cfg,
  input  logic            s1_take,
  output logic            s1_valid,
  output front_t          s1,
  output mem_req_t        mem_req
);

  logic [MODE_W-1:0]                effect_mode;
  logic [SHIFT_W-1:0]               ramp_shift;
  logic [NUM_TAPS-1:0][DIST_W-1:0]  tap_dist;
  logic [HIST_AW-1:0]               wp;
  logic [SEEN_W-1:0]                seen;
  logic                             parity;
  logic [RAMP_W-1:0]                ramp;
  logic                             falling;

  logic                             accept;
  logic [NUM_TAPS-1:0]              hit;
  logic [NUM_TAPS-1:0]              tap_en;
  logic [NUM_TAPS-1:0][HIST_AW-1:0] raddr;
  logic [SHIFT_W-1:0]               shift_c;
  logic [RAMP_W-1:0]                ramp_len;
  logic [RAMP_W-1:0]                ramp_next;
  logic                             falling_next;

  assign cfg.ready = 1'b1;
  assign din.ready = !s1_valid || s1_take;
  assign accept    = din.valid && din.ready;

  // Configuration registers; tap distances are formed when the delay is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= MODE_KEEP_EVEN;
      ramp_shift  <= SHIFT_RESET;
      tap_dist[0] <= DIST_W'(DELAY_RESET);
      tap_dist[1] <= DIST_W'({DELAY_RESET, 1'b0});
      tap_dist[2] <= DIST_W'({DELAY_RESET, 1'b0}) + DIST_W'(DELAY_RESET);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MODE: begin
          effect_mode <= cfg.data[MODE_W-1:0];
        end
        REG_DELAY: begin
          tap_dist[0] <= DIST_W'(cfg.data);
          tap_dist[1] <= DIST_W'({cfg.data, 1'b0});
          tap_dist[2] <= DIST_W'({cfg.data, 1'b0}) + DIST_W'(cfg.data);
        end
        REG_SHIFT: begin
          ramp_shift <= cfg.data[SHIFT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Tap addresses behind the write pointer, and whether each tap was written.
  always_comb begin
    logic [CALC_W-1:0] diff;
    logic [CALC_W-1:0] wrapped;
    for (int k = 0; k < NUM_TAPS; k++) begin
      diff    = CALC_W'(wp) - CALC_W'(tap_dist[k]);
      wrapped = diff[CALC_W-1] ? diff + CALC_W'(HISTORY_DEPTH) : diff;
      raddr[k] = wrapped[HIST_AW-1:0];
      hit[k]   = (tap_dist[k] != '0) && (CALC_W'(tap_dist[k]) <= CALC_W'(seen));
    end
  end

  // Taps that take part in the current mode.
  always_comb begin
    unique case (effect_mode) inside
      MODE_ECHO1:    tap_en = {1'b0, 1'b0, hit[0]};
      MODE_ECHO2:    tap_en = {1'b0, hit[1], hit[0]};
      MODE_ECHO3:    tap_en = hit;
      default:       tap_en = '0;
    endcase
  end

  // Envelope step: ramp up to the length, then back down to zero.
  always_comb begin
    shift_c      = (ramp_shift > MAX_SHIFT) ? MAX_SHIFT : ramp_shift;
    ramp_len     = RAMP_W'(1) << shift_c;
    ramp_next    = ramp;
    falling_next = falling;
    if (!falling) begin
      if (ramp != RAMP_MAX) begin
        ramp_next = ramp + RAMP_W'(1);
      end
      if (ramp_next >= ramp_len) begin
        falling_next = 1'b1;
      end
    end else begin
      if (ramp != '0) begin
        ramp_next = ramp - RAMP_W'(1);
      end
      if (ramp_next == '0) begin
        falling_next = 1'b0;
      end
    end
  end

  // Pointer, fill count and parity advance per transfer; the envelope state only in envelope mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      seen    <= '0;
      parity  <= 1'b0;
      ramp    <= '0;
      falling <= 1'b0;
    end else if (accept) begin
      wp     <= (wp == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp + HIST_AW'(1);
      parity <= !parity;
      if (seen != SEEN_W'(HISTORY_DEPTH)) begin
        seen <= seen + SEEN_W'(1);
      end
      if (effect_mode == MODE_ENVELOPE) begin
        ramp    <= ramp_next;
        falling <= falling_next;
      end
    end
  end

  // Item register aligned with the registered memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.mode   <= effect_mode;
      s1.x      <= din.sample_in;
      s1.parity <= parity;
      s1.tap_en <= tap_en;
      s1.ramp   <= ramp;
      s1.shift  <= shift_c;
    end
  end

  // History access: write the new sample, read all taps in the same cycle.
  assign mem_req.we    = accept;
  assign mem_req.waddr = wp;
  assign mem_req.wdata = din.sample_in;
  assign mem_req.re    = accept;
  assign mem_req.raddr = raddr;

  `MMAE_ASSERT(a_seen_tracks_wp, (seen != SEEN_W'(HISTORY_DEPTH)) |-> (seen == SEEN_W'(wp)), "fill count and write pointer disagree before the history is full")
  `MMAE_ASSERT(a_ramp_zero_rising, (ramp == '0) |-> !falling, "envelope falling at zero gain")
  `MMAE_ASSERT(a_tap3_needs_tap2, tap_en[2] |-> tap_en[1], "third tap used without the second")
  `MMAE_ASSERT(a_tap2_needs_tap1, tap_en[1] |-> tap_en[0], "second tap used without the first")

endmodule

// ----- hdl/mmae_datapath.sv -----
// ----------------------------------------------------------------------------
// Audio effect arithmetic pipeline
// Three register stages after the history read: tap sum and envelope product,
// magnitude and scaling, then mode select and saturation into the output
// register. Each stage advances when the stage after it can take its item.
// ----------------------------------------------------------------------------
module mmae_datapath import mmae_pkg::*; (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s1_valid,
  input  front_t                            s1,
  input  logic [NUM_TAPS-1:0][SAMPLE_W-1:0] tap_data,
  output logic                              s1_take,
  mmae_out_if.source                        dout
);

  // Signed saturation of a sign and magnitude pair to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_mag(input logic neg,
                                                         input logic [PROD_W-1:0] mag);
    logic signed [SAMPLE_W-1:0] res;
    if (neg) begin
      res = (mag > SAT_NEG_MAG) ? -$signed(SAT_NEG_MAG[SAMPLE_W-1:0])
                                : -$signed(mag[SAMPLE_W-1:0]);
    end else begin
      res = (mag > SAT_POS_MAG) ? $signed(SAT_POS_MAG[SAMPLE_W-1:0])
                                : $signed(mag[SAMPLE_W-1:0]);
    end
    return res;
  endfunction

  logic                       s2_valid;
  logic [MODE_W-1:0]          s2_mode;
  logic signed [SAMPLE_W-1:0] s2_x;
  logic                       s2_parity;
  logic [SHIFT_W-1:0]         s2_shift;
  logic signed [SUM_W-1:0]    s2_sum;
  logic signed [PROD_W-1:0]   s2_prod;

  logic                       s3_valid;
  logic [MODE_W-1:0]          s3_mode;
  logic signed [SAMPLE_W-1:0] s3_x;
  logic                       s3_parity;
  logic                       s3_sum_neg;
  logic [SUM_W-1:0]           s3_half;
  logic [DIVP_W-1:0]          s3_divp;
  logic                       s3_prod_neg;
  logic [PROD_W-1:0]          s3_env;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_data;

  logic                       out_free;
  logic                       s3_free;

  logic signed [SUM_W-1:0]    sum_acc;
  logic signed [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           div_in;
  logic [PROD_W-1:0]          prod_mag;
  logic [DIVP_W-1:0]          quot_wide;
  logic signed [SAMPLE_W-1:0] y;

  // Stage readiness back from the output register.
  assign out_free = !out_valid || dout.ready;
  assign s3_free  = !s3_valid || out_free;
  assign s1_take  = !s2_valid || s3_free;

  // Sum of the sample and the enabled taps; envelope gain product.
  always_comb begin
    sum_acc = SUM_W'($signed(s1.x));
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (s1.tap_en[k]) begin
        sum_acc = sum_acc + SUM_W'($signed(tap_data[k]));
      end
    end
    prod = PROD_W'($signed(s1.x)) * PROD_W'($signed({1'b0, s1.ramp}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_take) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2_mode   <= s1.mode;
      s2_x      <= s1.x;
      s2_parity <= s1.parity;
      s2_shift  <= s1.shift;
      s2_sum    <= sum_acc;
      s2_prod   <= prod;
    end
  end

  // Magnitudes, halving, division by five and the envelope shift.
  always_comb begin
    sum_mag  = s2_sum[SUM_W-1] ? SUM_W'(-s2_sum) : SUM_W'(s2_sum);
    div_in   = (s2_mode == MODE_ECHO2) ? SUM_W'({sum_mag, 1'b0}) : sum_mag;
    prod_mag = s2_prod[PROD_W-1] ? PROD_W'(-s2_prod) : PROD_W'(s2_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_mode     <= s2_mode;
      s3_x        <= s2_x;
      s3_parity   <= s2_parity;
      s3_sum_neg  <= s2_sum[SUM_W-1];
      s3_half     <= sum_mag >> 1;
      s3_divp     <= DIVP_W'(div_in) * DIVP_W'(DIV5_RECIP);
      s3_prod_neg <= s2_prod[PROD_W-1];
      s3_env      <= prod_mag >> s2_shift;
    end
  end

  // Mode select and saturation.
  assign quot_wide = s3_divp >> DIV5_SHIFT;

  always_comb begin
    unique case (s3_mode) inside
      MODE_KEEP_EVEN:         y = s3_parity ? '0 : s3_x;
      MODE_KEEP_ODD:          y = s3_parity ? s3_x : '0;
      MODE_ECHO1:             y = sat_mag(s3_sum_neg, PROD_W'(s3_half));
      MODE_ECHO2, MODE_ECHO3: y = sat_mag(s3_sum_neg, PROD_W'(quot_wide));
      MODE_ENVELOPE:          y = sat_mag(s3_prod_neg, s3_env);
      default:                y = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= y;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

endmodule

// ----- hdl/multi_mode_audio_effect_core.sv -----
// ----------------------------------------------------------------------------
// Multi-mode audio effect core
// One signed 16-bit sample in, one processed sample out: keep even or odd
// samples, a one to three tap feedforward echo, or a triangle envelope.
// ----------------------------------------------------------------------------
// The core takes one sample per clock and passes it through the history read,
// two arithmetic stages and the output register. Sustained throughput is one
// sample per clock, set by the single write and single read port of each
// history memory; the three echo taps are read from three identical copies of
// the 262144 x 16 history, all written with every sample. The history needs
// no clearing after reset, as a tap counts as zero until that many samples
// have been stored. Stalls on the output fill the internal stages before the
// input is held off. Configuration writes take effect on the next input
// transfer and are to be made only while no sample is in flight.
module multi_mode_audio_effect_core import mmae_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mmae_in_if.sink    din,
  mmae_cfg_if.sink   cfg,
  mmae_out_if.source dout
);

  logic                              s1_valid;
  logic                              s1_take;
  front_t                            s1;
  mem_req_t                          mem_req;
  logic [NUM_TAPS-1:0][SAMPLE_W-1:0] tap_data;

  // Configuration, pointers and history addressing.
  mmae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .cfg      (cfg),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1       (s1),
    .mem_req  (mem_req)
  );

  // One history copy per echo tap.
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_hist
    mmae_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (HISTORY_DEPTH)
    ) u_hist (
      .clk   (clk),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr[k]),
      .rdata (tap_data[k])
    );
  end

  // Arithmetic and output register.
  mmae_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .tap_data (tap_data),
    .s1_take  (s1_take),
    .dout     (dout)
  );

endmodule

// ----- bench/tb_multi_mode_audio_effect_core.sv -----
// ----------------------------------------------------------------------------
// Testbench for the multi-mode audio effect core
// Streams signed PCM samples through every effect mode and a range of register
// settings, with random gaps on the input and random stalls on the output. A
// predictor keeps its own sample history and envelope state and computes each
// expected output sample, and a monitor compares every output transfer in order.
// ----------------------------------------------------------------------------
module tb_multi_mode_audio_effect_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mmae_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 1125;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [DELAY_W-1:0] DELAY_TOP      = 17'd87381;
  localparam logic [DELAY_W-1:0] DELAY_ALL_ONES = 17'h1FFFF;
  localparam logic [SHIFT_W-1:0] SHIFT_ALL_ONES = 5'd31;

  // Mode codes past the envelope produce silence.
  localparam logic [MODE_W-1:0] MODE_SILENT_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SILENT_B = 3'd7;

  logic clk;
  logic rst;

  mmae_in_if  in_ch ();
  mmae_cfg_if cfg_ch ();
  mmae_out_if out_ch ();

  // Samples waiting to be offered, and output samples the predictor expects.
  logic signed [SAMPLE_W-1:0] pending_samples[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];

  // Predictor state and its copy of the registers.
  bit [SAMPLE_W-1:0]  history_mem [HISTORY_DEPTH];
  int unsigned        wr_ptr       = 0;
  int unsigned        seen_count   = 0;
  int unsigned        ramp_count   = 0;
  bit                 odd_index    = 1'b0;
  bit                 ramp_falling = 1'b0;
  logic [MODE_W-1:0]  cfg_mode     = MODE_KEEP_EVEN;
  logic [DELAY_W-1:0] cfg_delay    = DELAY_RESET;
  logic [SHIFT_W-1:0] cfg_shift    = SHIFT_RESET;

  // Traffic shaping.
  bit src_idle_on    = 1'b1;
  bit snk_idle_on    = 1'b1;
  bit sink_hold;
  bit pressure_armed = 1'b0;
  int src_wait;
  int snk_wait;

  // Bookkeeping.
  int error_count        = 0;
  int results_checked    = 0;
  int samples_accepted   = 0;
  int input_stall_cycles = 0;
  int cycle_count        = 0;
  int phase_count        = 0;

  multi_mode_audio_effect_core DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .cfg  (cfg_ch),
    .dout (out_ch)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample stored k times the base delay ago, or zero where it does not exist.
  function automatic longint history_tap(input int unsigned k);
    int unsigned reach;
    int unsigned idx;
    reach = k * cfg_delay;
    if (reach == 0 || reach > seen_count || reach > HISTORY_DEPTH) return 0;
    idx = (wr_ptr >= reach) ? wr_ptr - reach : wr_ptr + HISTORY_DEPTH - reach;
    return longint'(signed'(history_mem[idx]));
  endfunction

  // Computes the output for one accepted sample and advances the state.
  function automatic logic signed [SAMPLE_W-1:0] apply_effect(
    input logic signed [SAMPLE_W-1:0] x_in
  );
    longint x;
    longint y;
    longint prod;
    int unsigned sh;
    int unsigned span;
    x    = x_in;
    y    = 0;
    sh   = (cfg_shift > MAX_SHIFT) ? MAX_SHIFT : cfg_shift;
    span = 1 << sh;
    case (cfg_mode)
      MODE_KEEP_EVEN: y = odd_index ? 0 : x;
      MODE_KEEP_ODD:  y = odd_index ? x : 0;
      MODE_ECHO1:     y = (x + history_tap(1)) / 2;
      MODE_ECHO2:     y = (x + history_tap(1) + history_tap(2)) * 2 / 5;
      MODE_ECHO3:     y = (x + history_tap(1) + history_tap(2) + history_tap(3)) / 5;
      MODE_ENVELOPE: begin
        // Gain is applied first, then the triangle counter moves one step.
        prod = x * longint'(ramp_count);
        y = (prod >= 0) ? (prod >> sh) : -((-prod) >> sh);
        if (!ramp_falling) begin
          if (ramp_count < RAMP_MAX) ramp_count++;
          if (ramp_count >= span) ramp_falling = 1'b1;
        end else begin
          if (ramp_count > 0) ramp_count--;
          if (ramp_count == 0) ramp_falling = 1'b0;
        end
      end
      default: y = 0;
    endcase
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;

    // Every sample enters the history, whatever the mode.
    history_mem[wr_ptr] = x_in;
    wr_ptr = (wr_ptr + 1 >= HISTORY_DEPTH) ? 0 : wr_ptr + 1;
    if (seen_count < HISTORY_DEPTH) seen_count++;
    odd_index = !odd_index;
    return SAMPLE_W'(y);
  endfunction

  function automatic int pick_wait(input bit enabled);
    return enabled ? int'($urandom_range(0, 14)) : 0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Input driver: offers queued samples, predicts each one on its transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_wait    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_samples.insert(expected_samples.size(), apply_effect(in_ch.sample_in));
        samples_accepted++;
      end else if (in_ch.valid) begin
        input_stall_cycles++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_wait > 0) begin
          src_wait    <= src_wait - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_ch.sample_in <= pending_samples.pop_front();
          in_ch.valid     <= 1'b1;
          src_wait        <= pick_wait(src_idle_on);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each transfer against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    int next_wait;
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      snk_wait     <= 0;
    end else begin
      next_wait = snk_wait;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] output %0d arrived with nothing expected",
                     $time, out_ch.sample_out);
        end else begin
          want = expected_samples.pop_front();
          results_checked++;
          if (out_ch.sample_out !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("[%0t] output #%0d: expected %0d, got %0d",
                       $time, results_checked, want, out_ch.sample_out);
          end
        end
        next_wait = pick_wait(snk_idle_on);
      end
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
        snk_wait     <= next_wait;
      end else if (next_wait > 0) begin
        out_ch.ready <= 1'b0;
        snk_wait     <= next_wait - 1;
      end else begin
        out_ch.ready <= 1'b1;
        snk_wait     <= 0;
      end
    end
  end

  // Long output stall, so that the core fills up and holds off its input.
  initial begin : output_hold
    sink_hold = 1'b0;
    wait (pressure_armed);
    repeat (20) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d outputs still expected",
               cycle_count, expected_samples.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Waits until every queued sample has gone through and its output arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_ch.valid || expected_samples.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DELAY_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MODE:  cfg_mode  = value[MODE_W-1:0];
      REG_DELAY: cfg_delay = value;
      REG_SHIFT: cfg_shift = value[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  // Drains the core, then writes all three registers.
  task automatic reconfigure(input logic [MODE_W-1:0] mode,
                             input logic [DELAY_W-1:0] delay,
                             input logic [SHIFT_W-1:0] shift);
    wait_drained();
    write_reg(REG_MODE, DELAY_W'(mode));
    write_reg(REG_DELAY, delay);
    write_reg(REG_SHIFT, DELAY_W'(shift));
    @(negedge clk);
  endtask

  task automatic offer(input logic signed [SAMPLE_W-1:0] s);
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // Stimulus: directed corner cases, then random settings and samples.
  initial begin : stimulus
    int random_sent;
    int n;
    logic [MODE_W-1:0]  mode;
    logic [DELAY_W-1:0] delay;
    logic [SHIFT_W-1:0] shift;

    random_sent     = 0;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_MODE;
    cfg_ch.data     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Triple echo straight after reset: taps come into existence one by one.
    reconfigure(MODE_ECHO3, 17'd1, SHIFT_RESET);
    offer(SAMPLE_MAX); offer(SAMPLE_MAX); offer(SAMPLE_MAX);
    // Double echo saturating high, then low.
    reconfigure(MODE_ECHO2, 17'd1, SHIFT_RESET);
    offer(SAMPLE_MAX); offer(SAMPLE_MAX); offer(SAMPLE_MAX);
    offer(SAMPLE_MIN); offer(SAMPLE_MIN); offer(SAMPLE_MIN);
    reconfigure(MODE_ECHO1, 17'd2, SHIFT_RESET);
    offer(-16'sd1);
    // A zero delay and a delay whose third tap lies beyond the history.
    reconfigure(MODE_ECHO3, 17'd0, SHIFT_RESET);
    offer(-16'sd1000);
    reconfigure(MODE_ECHO3, DELAY_ALL_ONES, SHIFT_RESET);
    offer(16'sd12345);
    reconfigure(MODE_KEEP_EVEN, DELAY_RESET, SHIFT_RESET);
    offer(16'sh5555); offer(16'shAAAA); offer(-16'sd1);
    reconfigure(MODE_KEEP_ODD, DELAY_RESET, SHIFT_RESET);
    offer(16'sd1); offer(SAMPLE_MIN);
    reconfigure(MODE_SILENT_A, DELAY_RESET, SHIFT_RESET);
    offer(SAMPLE_MAX);
    reconfigure(MODE_SILENT_B, DELAY_RESET, SHIFT_RESET);
    offer(SAMPLE_MIN);
    // Envelope ramp, then a lower shift mid-ramp so the gain exceeds one.
    reconfigure(MODE_ENVELOPE, DELAY_RESET, 5'd3);
    offer(SAMPLE_MAX); offer(SAMPLE_MAX); offer(SAMPLE_MAX);
    reconfigure(MODE_ENVELOPE, DELAY_RESET, 5'd0);
    offer(SAMPLE_MAX); offer(SAMPLE_MIN);
    reconfigure(MODE_ENVELOPE, DELAY_RESET, SHIFT_ALL_ONES);
    offer(SAMPLE_MIN);

    // Random phases; one of them stalls the output for a long stretch.
    while (random_sent < RANDOM_ITEMS) begin
      phase_count++;
      if (phase_count == 8) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        reconfigure(MODE_ECHO2, DELAY_W'($urandom_range(1, 32)), SHIFT_RESET);
        pressure_armed = 1'b1;
        repeat (150) offer(draw_sample());
        random_sent += 150;
      end else begin
        case ($urandom_range(0, 11))
          0:       mode = MODE_KEEP_EVEN;
          1:       mode = MODE_KEEP_ODD;
          2, 8:    mode = MODE_ECHO1;
          3, 9:    mode = MODE_ECHO2;
          4, 10:   mode = MODE_ECHO3;
          5, 11:   mode = MODE_ENVELOPE;
          6:       mode = MODE_SILENT_A;
          default: mode = MODE_SILENT_B;
        endcase
        case ($urandom_range(0, 15))
          0:       delay = '0;
          1:       delay = DELAY_TOP;
          2:       delay = DELAY_ALL_ONES;
          3:       delay = DELAY_RESET;
          4, 5:    delay = DELAY_W'($urandom_range(65, 400));
          default: delay = DELAY_W'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 9))
          0:       shift = '0;
          1:       shift = MAX_SHIFT;
          2:       shift = SHIFT_ALL_ONES;
          3:       shift = SHIFT_W'($urandom_range(0, 31));
          default: shift = SHIFT_W'($urandom_range(1, 5));
        endcase
        src_idle_on = ($urandom_range(0, 3) != 0);
        snk_idle_on = ($urandom_range(0, 3) != 0);
        n = $urandom_range(15, 70);
        reconfigure(mode, delay, shift);
        repeat (n) offer(draw_sample());
        random_sent += n;
      end
    end

    wait_drained();
    $display("Covered %0d samples over %0d random setting phases, all eight modes.",
             samples_accepted, phase_count);
    $display("Checked %0d outputs; input held off for %0d cycles; %0d errors.",
             results_checked, input_stall_cycles, error_count);
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
